### rtl/core/pdl_pkg.sv
`default_nettype none
package pdl_pkg;

  // Entry fields carry seven bytes; wider password settings clip to that.
  localparam int FIELD_BYTES = 7;
  localparam int FIELD_W     = 8 * FIELD_BYTES;

  localparam int ENTRY_BYTES_DEF = 7;
  localparam int SAVED_BYTES_DEF = 5;

  // Result queue; depth must be a power of two.
  localparam int RBUF_DEPTH = 4;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [7:0] SYM_OPEN   = 8'h2B;
  localparam logic [7:0] SYM_CHANGE = 8'h2D;

  localparam logic [7:0] OPEN_TICKS_RST   = 8'd5;
  localparam logic [7:0] HOLD_TICKS_RST   = 8'd1;
  localparam logic [7:0] ALARM_TICKS_RST  = 8'd20;
  localparam logic [3:0] MAX_ATTEMPTS_RST = 4'd3;

  typedef enum logic [1:0] {
    CMD_NEWPW = 2'd0,
    CMD_MENU  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_AWAIT = 2'd0,
    MODE_MENU  = 2'd1,
    MODE_DOOR  = 2'd2,
    MODE_ALARM = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REPLY_NONE     = 2'd0,
    REPLY_MATCH    = 2'd1,
    REPLY_MISMATCH = 2'd2
  } reply_t;

  typedef enum logic [1:0] {
    MOTOR_STOP = 2'd0,
    MOTOR_CW   = 2'd1,
    MOTOR_CCW  = 2'd2
  } motor_t;

  typedef enum logic [1:0] {
    STEP_OPEN  = 2'd0,
    STEP_HOLD  = 2'd1,
    STEP_CLOSE = 2'd2
  } step_t;

  typedef enum logic [1:0] {
    REG_OPEN_TICKS   = 2'd0,
    REG_HOLD_TICKS   = 2'd1,
    REG_ALARM_TICKS  = 2'd2,
    REG_MAX_ATTEMPTS = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] open_ticks;
    logic [7:0] hold_ticks;
    logic [7:0] alarm_ticks;
    logic [3:0] max_attempts;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [FIELD_W-1:0] first_entry;
    logic [FIELD_W-1:0] second_entry;
    logic [7:0]         menu_symbol;
  } in_item_t;

  typedef struct packed {
    reply_t reply;
    motor_t motor_drive;
    logic   buzzer;
    mode_t  mode;
    logic   last;
  } out_item_t;

  typedef struct packed {
    logic pair_eq;
    logic saved_eq;
  } lane_flags_t;

  typedef struct packed {
    logic push;
    logic dual;
  } push_t;

  function automatic int eff_bytes(input int n);
    return (n > FIELD_BYTES) ? FIELD_BYTES : n;
  endfunction

  function automatic int lane_count(input int a, input int b);
    return (eff_bytes(a) > eff_bytes(b)) ? eff_bytes(a) : eff_bytes(b);
  endfunction

endpackage
`default_nettype wire

### rtl/core/pdl_lane.sv
`default_nettype none
module pdl_lane
  import pdl_pkg::*;
(
  input  wire logic [7:0]  first_byte,
  input  wire logic [7:0]  second_byte,
  input  wire logic [7:0]  saved_byte,
  output lane_flags_t      flags
);

  // Compare one byte position against the confirmation and the stored password.
  assign flags.pair_eq  = (first_byte == second_byte);
  assign flags.saved_eq = (first_byte == saved_byte);

endmodule
`default_nettype wire

### rtl/core/pdl_ctrl.sv
`default_nettype none
module pdl_ctrl
  import pdl_pkg::*;
#(
  parameter int ENTRY_BYTES = ENTRY_BYTES_DEF,
  parameter int SAVED_BYTES = SAVED_BYTES_DEF,
  localparam int ENTRY_EFF  = eff_bytes(ENTRY_BYTES),
  localparam int SAVED_EFF  = eff_bytes(SAVED_BYTES),
  localparam int LANES      = lane_count(ENTRY_BYTES, SAVED_BYTES),
  localparam int SAVED_W    = 8 * SAVED_EFF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   accept,
  input  wire in_item_t               item,
  input  wire cfg_t                   cfg,
  input  wire lane_flags_t [LANES-1:0] flags,
  output logic [SAVED_W-1:0]          saved_pw,
  output push_t                       push,
  output out_item_t                   res0,
  output out_item_t                   res1
);

  mode_t              mode_r, mode_nxt;
  step_t              step_r, step_nxt;
  logic [3:0]         fails_r, fails_nxt, fails_inc;
  logic [7:0]         tick_r, tick_nxt, limit;
  logic [8:0]         tick_inc;
  logic               tick_done;
  logic [SAVED_W-1:0] saved_r;
  logic               save_en;
  logic               pair_match, saved_match;
  reply_t             reply;
  logic               lockout;
  motor_t             motor;
  out_item_t          final_item;

  // Merge the lane verdicts.
  always_comb begin
    pair_match  = 1'b1;
    saved_match = 1'b1;
    for (int i = 0; i < LANES; i++) begin
      if (i < ENTRY_EFF) pair_match  = pair_match  & flags[i].pair_eq;
      if (i < SAVED_EFF) saved_match = saved_match & flags[i].saved_eq;
    end
  end

  // Phase timer: length depends on mode and door step.
  always_comb begin
    if (mode_r == MODE_ALARM)      limit = cfg.alarm_ticks;
    else if (step_r == STEP_HOLD)  limit = cfg.hold_ticks;
    else                           limit = cfg.open_ticks;
    tick_inc  = {1'b0, tick_r} + 9'd1;
    tick_done = (tick_inc >= {1'b0, limit});
  end

  assign fails_inc = fails_r + 4'd1;

  // Next state.
  always_comb begin
    mode_nxt  = mode_r;
    step_nxt  = step_r;
    fails_nxt = fails_r;
    tick_nxt  = tick_r;
    save_en   = 1'b0;
    reply     = REPLY_NONE;
    lockout   = 1'b0;
    if (accept) begin
      unique case (mode_r)
        MODE_AWAIT: begin
          if (item.command == CMD_NEWPW) begin
            if (pair_match) begin
              reply     = REPLY_MATCH;
              save_en   = 1'b1;
              fails_nxt = 4'd0;
              mode_nxt  = MODE_MENU;
            end else begin
              reply = REPLY_MISMATCH;
            end
          end
        end
        MODE_MENU: begin
          if (item.command == CMD_MENU) begin
            if (saved_match) begin
              reply = REPLY_MATCH;
              if (item.menu_symbol == SYM_OPEN) begin
                mode_nxt = MODE_DOOR;
                step_nxt = STEP_OPEN;
                tick_nxt = 8'd0;
              end else if (item.menu_symbol == SYM_CHANGE) begin
                mode_nxt = MODE_AWAIT;
              end
            end else begin
              reply = REPLY_MISMATCH;
              if (fails_inc >= cfg.max_attempts || fails_inc == 4'd0) begin
                lockout   = 1'b1;
                fails_nxt = 4'd0;
                mode_nxt  = MODE_ALARM;
                tick_nxt  = 8'd0;
              end else begin
                fails_nxt = fails_inc;
              end
            end
          end
        end
        MODE_DOOR: begin
          if (item.command == CMD_TICK) begin
            tick_nxt = tick_done ? 8'd0 : tick_inc[7:0];
            if (tick_done) begin
              unique case (step_r)
                STEP_OPEN: step_nxt = STEP_HOLD;
                STEP_HOLD: step_nxt = STEP_CLOSE;
                default: begin
                  step_nxt = STEP_OPEN;
                  mode_nxt = MODE_AWAIT;
                end
              endcase
            end
          end
        end
        MODE_ALARM: begin
          if (item.command == CMD_TICK) begin
            tick_nxt = tick_done ? 8'd0 : tick_inc[7:0];
            if (tick_done) mode_nxt = MODE_AWAIT;
          end
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  // The final result shows the state after the transaction; a lockout's first result shows the menu mode.
  always_comb begin
    motor = MOTOR_STOP;
    if (mode_nxt == MODE_DOOR) begin
      if (step_nxt == STEP_OPEN)       motor = MOTOR_CW;
      else if (step_nxt == STEP_CLOSE) motor = MOTOR_CCW;
    end
    final_item.reply       = reply;
    final_item.motor_drive = motor;
    final_item.buzzer      = (mode_nxt == MODE_ALARM);
    final_item.mode        = mode_nxt;
    final_item.last        = 1'b1;
    res1 = final_item;
    if (lockout) begin
      res0.reply       = REPLY_MISMATCH;
      res0.motor_drive = MOTOR_STOP;
      res0.buzzer      = 1'b0;
      res0.mode        = MODE_MENU;
      res0.last        = 1'b0;
    end else begin
      res0 = final_item;
    end
    push.push = accept;
    push.dual = lockout;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_AWAIT;
      step_r  <= STEP_OPEN;
      fails_r <= 4'd0;
      tick_r  <= 8'd0;
    end else begin
      mode_r  <= mode_nxt;
      step_r  <= step_nxt;
      fails_r <= fails_nxt;
      tick_r  <= tick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (save_en) saved_r <= item.first_entry[SAVED_W-1:0];
  end

  assign saved_pw = saved_r;

endmodule
`default_nettype wire

### rtl/core/pdl_rbuf.sv
`default_nettype none
module pdl_rbuf
  import pdl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire push_t     push,
  input  wire out_item_t res0,
  input  wire out_item_t res1,
  output logic           room,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam int PTR_W = $clog2(RBUF_DEPTH);
  localparam int CNT_W = $clog2(RBUF_DEPTH + 1);

  out_item_t         mem_r [RBUF_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_2;
  logic [CNT_W-1:0]  count_r, count_nxt, push_n;
  logic              pop;

  assign pop       = out_valid & ~out_stall;
  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign room      = (count_r <= CNT_W'(RBUF_DEPTH - 2));
  assign wr_ptr_2  = wr_ptr_r + PTR_W'(1);

  always_comb begin
    push_n     = push.push ? (push.dual ? CNT_W'(2) : CNT_W'(1)) : '0;
    count_nxt  = count_r + push_n - CNT_W'(pop);
    wr_ptr_nxt = wr_ptr_r + push_n[PTR_W-1:0];
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push)             mem_r[wr_ptr_r] <= res0;
    if (push.push & push.dual) mem_r[wr_ptr_2] <= res1;
  end

endmodule
`default_nettype wire

### rtl/core/password_door_lock_controller.sv
`default_nettype none
// Password door lock controller. Each input transaction carries a command:
// a new password pair (two 7-byte entries that must agree; the low bytes of
// the first are stored and the lock enters its menu), a menu request (an
// entry checked against the stored password plus a symbol, '+' to run the
// door sequence and '-' to set a new password), or a timer tick that steps
// the motor sequence and the lockout alarm. Every transaction gives one
// result; a failed check that reaches max_attempts gives two, the failed
// reply and then the lockout notice with the buzzer on. Transactions that
// do not fit the current mode change nothing and reply "none". One
// transaction is accepted per clock while in_stall is low: the byte lanes
// compare all password bytes side by side, the merge and the state update
// finish in the same cycle, and results wait in a four-entry queue. in_stall
// rises only when that queue has fewer than two free entries, so with
// out_stall low the block takes one transaction per cycle and each result
// is registered into the queue before it shows at the output; the output
// moves one result per cycle, so each lockout notice adds a result, and
// closely spaced lockouts can fill the queue and hold the input.
// Registers at byte address 4*i: open_ticks, hold_ticks, alarm_ticks,
// max_attempts; write them only while the block is idle.
module password_door_lock_controller
  import pdl_pkg::*;
#(
  parameter int ENTRY_BYTES = ENTRY_BYTES_DEF,
  parameter int SAVED_BYTES = SAVED_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready
);

  localparam int SAVED_EFF = eff_bytes(SAVED_BYTES);
  localparam int LANES     = lane_count(ENTRY_BYTES, SAVED_BYTES);
  localparam int SAVED_W   = 8 * SAVED_EFF;

  cfg_t                    cfg_r, cfg_nxt;
  reg_idx_t                reg_idx;
  logic                    cfg_wr;
  logic                    accept;
  logic                    room;
  lane_flags_t [LANES-1:0] flags;
  logic [SAVED_W-1:0]      saved_pw;
  push_t                   push;
  out_item_t               res0, res1;

  // Configuration port: zero-wait APB, write on the access phase.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_OPEN_TICKS:   cfg_nxt.open_ticks   = pwdata[7:0];
        REG_HOLD_TICKS:   cfg_nxt.hold_ticks   = pwdata[7:0];
        REG_ALARM_TICKS:  cfg_nxt.alarm_ticks  = pwdata[7:0];
        REG_MAX_ATTEMPTS: cfg_nxt.max_attempts = pwdata[3:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_OPEN_TICKS:   prdata = CFG_DATA_W'(cfg_r.open_ticks);
      REG_HOLD_TICKS:   prdata = CFG_DATA_W'(cfg_r.hold_ticks);
      REG_ALARM_TICKS:  prdata = CFG_DATA_W'(cfg_r.alarm_ticks);
      REG_MAX_ATTEMPTS: prdata = CFG_DATA_W'(cfg_r.max_attempts);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.open_ticks   <= OPEN_TICKS_RST;
      cfg_r.hold_ticks   <= HOLD_TICKS_RST;
      cfg_r.alarm_ticks  <= ALARM_TICKS_RST;
      cfg_r.max_attempts <= MAX_ATTEMPTS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Hold off new transactions only while the queue cannot take a lockout pair.
  assign in_stall = ~room;
  assign accept   = in_valid & ~in_stall;

  // One lane per password byte; lanes past the stored length see no saved byte.
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    if (g < SAVED_EFF) begin : g_saved
      pdl_lane u_lane (
        .first_byte  (in_data.first_entry[8*g +: 8]),
        .second_byte (in_data.second_entry[8*g +: 8]),
        .saved_byte  (saved_pw[8*g +: 8]),
        .flags       (flags[g])
      );
    end else begin : g_plain
      pdl_lane u_lane (
        .first_byte  (in_data.first_entry[8*g +: 8]),
        .second_byte (in_data.second_entry[8*g +: 8]),
        .saved_byte  (8'h00),
        .flags       (flags[g])
      );
    end
  end

  // Merge the lanes and advance the lock state.
  pdl_ctrl #(
    .ENTRY_BYTES (ENTRY_BYTES),
    .SAVED_BYTES (SAVED_BYTES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_data),
    .cfg      (cfg_r),
    .flags    (flags),
    .saved_pw (saved_pw),
    .push     (push),
    .res0     (res0),
    .res1     (res1)
  );

  // Queue results so the input keeps flowing while the output is stalled.
  pdl_rbuf u_rbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res0      (res0),
    .res1      (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

### rtl/core/pdl_checker.sv
`default_nettype none
module pdl_checker
  import pdl_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The lockout notice is queued together with the failed reply.
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last |=> out_valid)
    else $error("second result of a lockout missing");

  // Only the failed check before a lockout is a non-final result.
  a_first_of_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |->
      out_data.reply == REPLY_MISMATCH && out_data.mode == MODE_MENU)
    else $error("unexpected non-final result");

  // Buzzer and motor follow the mode.
  a_buzzer_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.buzzer == (out_data.mode == MODE_ALARM)))
    else $error("buzzer does not match alarm mode");

  a_motor_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.motor_drive != MOTOR_STOP |-> out_data.mode == MODE_DOOR)
    else $error("motor runs outside the door sequence");

endmodule

bind password_door_lock_controller pdl_checker u_pdl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
